// File: hw/rtl/tmc_pkg.sv
`default_nettype none

package tmc_pkg;

  // Lepton choice codes; the unused code selects the third lepton
  localparam logic [1:0] LEP_LEAD    = 2'd0;
  localparam logic [1:0] LEP_SUBLEAD = 2'd1;
  localparam logic [1:0] LEP_THIRD   = 2'd2;

  // pi in Q30
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // Fixed widths of the Q30 sine datapath
  localparam int Y_W  = 31;  // half angle in radians, at most pi/2
  localparam int Y2_W = 32;  // its square, below 2.47
  localparam int T_W  = 31;  // series factor, in (0, 1]
  localparam int X_W  = 32;  // series product before division
  localparam int Q_W  = 30;  // series quotient
  localparam int V2_W = 19;  // 2 * (1 - cos) in Q16

  localparam logic [T_W-1:0] ONE_Q30 = T_W'(1) << 30;

  // Series divisors, innermost first, with floor(2^32 / k)
  localparam int TAYLOR_STEPS = 5;
  localparam logic [6:0] TAYLOR_DIV [TAYLOR_STEPS] = '{
    7'd110, 7'd72, 7'd42, 7'd20, 7'd6
  };
  localparam logic [Q_W-1:0] TAYLOR_RECIP [TAYLOR_STEPS] = '{
    30'd39045157, 30'd59652323, 30'd102261126, 30'd214748364, 30'd715827882
  };

endpackage

`default_nettype wire

// File: hw/rtl/transverse_mass_calc_core.sv
`default_nettype none
// Datapath: the fold, radian and square stages, the five-step sine series (four stages per
//   step), the sine and mass stages, the one-bit-per-stage root and the output buffer head.
// Throughput: one transaction per cycle; a two-entry output buffer lets input continue
//   while a result waits, and a full buffer with out_ready low stalls every stage together.
// Reset (rst_n low, synchronous): all valid bits and the output buffer clear, and the
//   lepton choice returns to the leading lepton.
module transverse_mass_calc_core
  import tmc_pkg::*;
#(
  parameter int MOMENTUM_BITS = 16,
  parameter int ANGLE_BITS    = 12
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_wr_en,
  input  wire  [1:0]                      cfg_wr_data,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [MOMENTUM_BITS-1:0]        in_lead_pt,
  input  wire  signed [ANGLE_BITS-1:0]    in_lead_phi,
  input  wire  [MOMENTUM_BITS-1:0]        in_sublead_pt,
  input  wire  signed [ANGLE_BITS-1:0]    in_sublead_phi,
  input  wire  [MOMENTUM_BITS-1:0]        in_third_pt,
  input  wire  signed [ANGLE_BITS-1:0]    in_third_phi,
  input  wire  [MOMENTUM_BITS-1:0]        in_met_value,
  input  wire  signed [ANGLE_BITS-1:0]    in_met_phi,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [MOMENTUM_BITS:0]          out_trans_mass
);

  localparam int MW = MOMENTUM_BITS;
  localparam int AW = ANGLE_BITS;
  localparam int PW = 2 * MW;        // pt * met
  localparam int NW = 2 * MW + 2;    // mass squared
  localparam int OW = MW + 1;        // root, one stage per bit
  localparam int RW = MW + 4;        // root remainder
  localparam logic [AW:0] FULL_TURN = (AW+1)'(1) << AW;
  localparam logic [AW:0] HALF_TURN = (AW+1)'(1) << (AW - 1);

  // Values that ride along the sine series
  typedef struct packed {
    logic [Y_W-1:0]  y;
    logic [Y2_W-1:0] y2;
    logic [PW-1:0]   p;
  } carry_t;

  // ---------------------------------------------------------------------------
  // Global advance: every stage moves when the output buffer has a free slot or
  // its head is being taken. A stalled stage simply holds its contents.
  // ---------------------------------------------------------------------------
  logic adv;
  logic head_v_r, spare_v_r;
  logic [OW-1:0] head_d_r, spare_d_r;

  assign adv      = !spare_v_r || out_ready;
  assign in_ready = adv;

  // Configuration register
  logic [1:0] lep_choice_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lep_choice_r <= LEP_LEAD;
    end else if (cfg_wr_en) begin
      lep_choice_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: pick the lepton and fold |dphi| into [0, pi]
  // ---------------------------------------------------------------------------
  logic [MW-1:0]        sel_pt;
  logic signed [AW-1:0] sel_phi;
  logic signed [AW:0]   dphi;
  logic [AW:0]          adiff;
  logic [AW-1:0]        fold_nxt;

  always_comb begin
    case (lep_choice_r)
      LEP_LEAD: begin
        sel_pt  = in_lead_pt;
        sel_phi = in_lead_phi;
      end
      LEP_SUBLEAD: begin
        sel_pt  = in_sublead_pt;
        sel_phi = in_sublead_phi;
      end
      default: begin
        sel_pt  = in_third_pt;
        sel_phi = in_third_phi;
      end
    endcase
    dphi  = (AW+1)'(sel_phi) - (AW+1)'(in_met_phi);
    adiff = dphi[AW] ? (AW+1)'(-dphi) : (AW+1)'(dphi);
    // past half a turn, measure the other way round
    if (adiff >= HALF_TURN) begin
      fold_nxt = AW'(FULL_TURN - adiff);
    end else begin
      fold_nxt = adiff[AW-1:0];
    end
  end

  logic          v0_r;
  logic [MW-1:0] pt0_r, met0_r;
  logic [AW-1:0] diff0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt0_r   <= sel_pt;
      met0_r  <= in_met_value;
      diff0_r <= fold_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: half angle in radians (Q30) and the momentum product
  // ---------------------------------------------------------------------------
  logic [AW+31:0] yprod;
  logic           v1_r;
  logic [Y_W-1:0] y1_r;
  logic [PW-1:0]  p1_r;

  assign yprod = (AW+32)'(diff0_r) * (AW+32)'(PI_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y1_r <= yprod[AW+30:AW];
      p1_r <= PW'(pt0_r) * PW'(met0_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: square of the half angle
  // ---------------------------------------------------------------------------
  logic [61:0] ysq;
  logic        v2_r;
  carry_t      cr2_r;

  assign ysq = 62'(y1_r) * 62'(y1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cr2_r.y  <= y1_r;
      cr2_r.y2 <= ysq[61:30];
      cr2_r.p  <= p1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Sine series, nested form: t = 1 - y2 * t / k, one term per four stages.
  //   a: y2 * t        b: times floor(2^32/k)
  //   c: estimate * k  d: fix the estimate by one, form the new t
  // ---------------------------------------------------------------------------
  logic           iv  [TAYLOR_STEPS+1];
  carry_t         icr [TAYLOR_STEPS+1];
  logic [T_W-1:0] it  [TAYLOR_STEPS+1];

  assign iv[0]  = v2_r;
  assign icr[0] = cr2_r;
  assign it[0]  = ONE_Q30;

  for (genvar i = 0; i < TAYLOR_STEPS; i++) begin : g_term
    logic           va_r, vb_r, vc_r, vd_r;
    carry_t         cra_r, crb_r, crc_r, crd_r;
    logic [X_W-1:0] xa_r, xb_r, xc_r;
    logic [Q_W-1:0] qb_r, qc_r;
    logic [X_W-1:0] qkc_r;
    logic [T_W-1:0] td_r;
    logic [62:0]    tprod;
    logic [61:0]    rprod;
    logic [36:0]    kprod;
    logic [X_W-1:0] rem;
    logic [T_W-1:0] q_fix;

    assign tprod = 63'(icr[i].y2) * 63'(it[i]);
    assign rprod = 62'(xa_r) * 62'(TAYLOR_RECIP[i]);
    assign kprod = 37'(qb_r) * 37'(TAYLOR_DIV[i]);
    assign rem   = xc_r - qkc_r;
    // the reciprocal estimate is low by at most one
    assign q_fix = T_W'(qc_r) + T_W'(rem >= X_W'(TAYLOR_DIV[i]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r <= 1'b0;
        vb_r <= 1'b0;
        vc_r <= 1'b0;
        vd_r <= 1'b0;
      end else if (adv) begin
        va_r <= iv[i];
        vb_r <= va_r;
        vc_r <= vb_r;
        vd_r <= vc_r;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cra_r <= icr[i];
        xa_r  <= tprod[61:30];
        crb_r <= cra_r;
        xb_r  <= xa_r;
        qb_r  <= rprod[61:32];
        crc_r <= crb_r;
        xc_r  <= xb_r;
        qc_r  <= qb_r;
        qkc_r <= kprod[X_W-1:0];
        crd_r <= crc_r;
        td_r  <= ONE_Q30 - q_fix;
      end
    end

    assign iv[i+1]  = vd_r;
    assign icr[i+1] = crd_r;
    assign it[i+1]  = td_r;
  end

  // ---------------------------------------------------------------------------
  // Sine of the half angle, then 2 * (1 - cos) in Q16
  // ---------------------------------------------------------------------------
  logic [61:0]    sprod;
  logic           vs_r;
  logic [Y_W-1:0] s_r;
  logic [PW-1:0]  ps_r;

  assign sprod = 62'(icr[TAYLOR_STEPS].y) * 62'(it[TAYLOR_STEPS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else if (adv) begin
      vs_r <= iv[TAYLOR_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r  <= sprod[60:30];
      ps_r <= icr[TAYLOR_STEPS].p;
    end
  end

  logic [Y_W-1:0]  s_clip;
  logic [61:0]     s2prod;
  logic [31:0]     v_sum;
  logic            vv_r;
  logic [V2_W-1:0] omc2_r;
  logic [PW-1:0]   pv_r;

  // clamp sine to one; rounding (2*s2 + 2^13) >> 14 equals (s2 + 2^12) >> 13
  assign s_clip = (s_r > ONE_Q30) ? ONE_Q30 : s_r;
  assign s2prod = 62'(s_clip) * 62'(s_clip);
  assign v_sum  = 32'(s2prod[60:30]) + 32'd4096;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vv_r <= 1'b0;
    end else if (adv) begin
      vv_r <= vs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      omc2_r <= {v_sum[30:13], 1'b0};
      pv_r   <= ps_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Mass squared: floor(pt * met * 2(1 - cos) / 2^16)
  // ---------------------------------------------------------------------------
  logic [PW+18:0] mprod;
  logic           vm_r;
  logic [NW-1:0]  m2_r;

  assign mprod = (PW+19)'(pv_r) * (PW+19)'(omc2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (adv) begin
      vm_r <= vv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r <= mprod[PW+17:16];
    end
  end

  // ---------------------------------------------------------------------------
  // Integer square root, one result bit per stage, most significant first
  // ---------------------------------------------------------------------------
  logic          qv    [OW+1];
  logic [RW-1:0] qrem  [OW+1];
  logic [OW-1:0] qroot [OW+1];
  logic [NW-1:0] qn    [OW+1];

  assign qv[0]    = vm_r;
  assign qrem[0]  = '0;
  assign qroot[0] = '0;
  assign qn[0]    = m2_r;

  for (genvar j = 0; j < OW; j++) begin : g_root
    logic          sv_r;
    logic [RW-1:0] srem_r;
    logic [OW-1:0] sroot_r;
    logic [NW-1:0] sn_r;
    logic [RW-1:0] rem_sh, trial;
    logic          take;

    assign rem_sh = {qrem[j][RW-3:0], qn[j][NW-1:NW-2]};
    assign trial  = RW'({qroot[j], 2'b01});
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r <= 1'b0;
      end else if (adv) begin
        sv_r <= qv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        srem_r  <= take ? (rem_sh - trial) : rem_sh;
        sroot_r <= {qroot[j][OW-2:0], take};
        sn_r    <= {qn[j][NW-3:0], 2'b00};
      end
    end

    assign qv[j+1]    = sv_r;
    assign qrem[j+1]  = srem_r;
    assign qroot[j+1] = sroot_r;
    assign qn[j+1]    = sn_r;
  end

  // ---------------------------------------------------------------------------
  // Output buffer: head drives the port, spare catches the one transaction that
  // may arrive while the head is held.
  // ---------------------------------------------------------------------------
  logic push, pop;

  assign push = adv && qv[OW];
  assign pop  = head_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r  <= 1'b0;
      spare_v_r <= 1'b0;
    end else if (pop) begin
      if (spare_v_r) begin
        // advance spare to head, refill spare
        head_d_r  <= spare_d_r;
        spare_v_r <= push;
        spare_d_r <= qroot[OW];
      end else begin
        head_v_r <= push;
        head_d_r <= qroot[OW];
      end
    end else if (!head_v_r) begin
      head_v_r <= push;
      head_d_r <= qroot[OW];
    end else if (push) begin
      // head is held; spare is known empty here
      spare_v_r <= 1'b1;
      spare_d_r <= qroot[OW];
    end
  end

  assign out_valid      = head_v_r;
  assign out_trans_mass = head_d_r;

endmodule

`default_nettype wire
